// ===== rtl/core/ple_pkg.sv =====
// types, codes and defaults shared by the positional list engine
package ple_pkg;

    localparam int DEPTH_DEF = 32;

    typedef enum logic [3:0] {
        OP_INS_FRONT = 4'd0,
        OP_INS_BACK  = 4'd1,
        OP_INS_AT    = 4'd2,
        OP_DEL_FRONT = 4'd3,
        OP_DEL_BACK  = 4'd4,
        OP_DEL_AT    = 4'd5,
        OP_UPDATE    = 4'd6,
        OP_SEARCH    = 4'd7,
        OP_CLEAR     = 4'd8,
        OP_SIZE      = 4'd9,
        OP_DUMP      = 4'd10
    } t_op;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_RANGE    = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_FULL     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPEN,
        ST_CLOSE,
        ST_SEARCH,
        ST_DUMP
    } t_state;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] value;
        logic [5:0]         pos;
    } t_cmd;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] item_value;
        logic [5:0]         item_pos;
        logic [5:0]         length;
        logic               last;
    } t_result;

endpackage

// ===== rtl/core/positional_list_engine.sv =====
// positional list engine: ordered list of signed words kept in one memory
//
// A command is taken on i_cmd at a clock edge where start is high and busy is
// low. Each result is shown on o_result for exactly one cycle with o_strobe
// high; the receiver cannot hold results off, and o_result.last marks the
// final result of a command.
// Size, clear, update, back insert, back delete and every error status are
// done from idle: the result follows on the next cycle and busy stays low, so
// such commands may come back to back. Front or positional insert moves the
// tail up one entry a cycle, then writes the new word; front or positional
// delete moves it down the same way. Dump gives one result per cycle; search
// holds each hit back until the next hit or the end settles last, then gives
// it. The moves are paced by the single read and single write port of the
// element memory.
// Reset empties the list and leaves the memory contents as they are.
module positional_list_engine #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  ple_pkg::t_cmd    i_cmd,
    output logic             o_strobe,
    output ple_pkg::t_result o_result
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 6) ? CW : 6;

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    ple_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_left, n_left;
    logic [IW-1:0]    r_idx, n_idx;
    logic [IW-1:0]    r_base, n_base;
    logic [31:0]      r_val, n_val;
    logic             r_pend, n_pend;
    logic [IW-1:0]    r_pend_addr, n_pend_addr;
    logic             r_hit_vld, n_hit_vld;
    logic [31:0]      r_hit_val, n_hit_val;
    logic [5:0]       r_hit_pos, n_hit_pos;
    logic             r_strobe, n_strobe;
    ple_pkg::t_result r_out, n_out;

    logic          mem_we;
    logic [IW-1:0] mem_wa, mem_ra;
    logic [31:0]   mem_wd;

    logic          accept, full, empty, pos_ok, ins_ok;
    logic [5:0]    pos_m1;
    logic [IW-1:0] at, at_p1;
    logic [CW-1:0] cnt_m1, pend_pos;

    assign accept   = start && (r_state == ple_pkg::ST_IDLE);
    assign full     = (r_count == CW'(DEPTH));
    assign empty    = (r_count == '0);
    assign pos_ok   = (i_cmd.pos != 6'd0) && (XW'(i_cmd.pos) <= XW'(r_count));
    assign ins_ok   = (i_cmd.pos == 6'd1) || pos_ok;
    assign pos_m1   = i_cmd.pos - 6'd1;
    assign at       = pos_m1[IW-1:0];
    assign at_p1    = at + IW'(1);
    assign cnt_m1   = r_count - CW'(1);
    assign pend_pos = CW'(r_pend_addr) + CW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ple_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_cmd.op)
                        ple_pkg::OP_INS_FRONT: if (!full) n_state = ple_pkg::ST_OPEN;
                        ple_pkg::OP_INS_AT: if (!full && ins_ok) n_state = ple_pkg::ST_OPEN;
                        ple_pkg::OP_DEL_FRONT: if (!empty) n_state = ple_pkg::ST_CLOSE;
                        ple_pkg::OP_DEL_AT: if (!empty && pos_ok) n_state = ple_pkg::ST_CLOSE;
                        ple_pkg::OP_SEARCH: if (!empty) n_state = ple_pkg::ST_SEARCH;
                        ple_pkg::OP_DUMP: if (!empty) n_state = ple_pkg::ST_DUMP;
                        default: n_state = ple_pkg::ST_IDLE;
                    endcase
                end
            end
            ple_pkg::ST_OPEN, ple_pkg::ST_CLOSE, ple_pkg::ST_SEARCH: begin
                if (!r_pend && r_left == '0) n_state = ple_pkg::ST_IDLE;
            end
            ple_pkg::ST_DUMP: begin
                if (r_pend && r_left == '0) n_state = ple_pkg::ST_IDLE;
            end
            default: n_state = ple_pkg::ST_IDLE;
        endcase
    end

    // datapath, memory access and results
    always_comb begin
        n_count     = r_count;
        n_left      = r_left;
        n_idx       = r_idx;
        n_base      = r_base;
        n_val       = r_val;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_hit_vld   = r_hit_vld;
        n_hit_val   = r_hit_val;
        n_hit_pos   = r_hit_pos;
        n_strobe    = 1'b0;
        n_out       = '0;
        n_out.status = ple_pkg::STAT_OK;
        mem_we      = 1'b0;
        mem_wa      = '0;
        mem_wd      = '0;
        mem_ra      = r_idx;

        unique case (r_state)
            ple_pkg::ST_IDLE: begin
                if (accept) begin
                    n_val = i_cmd.value;
                    unique case (i_cmd.op)
                        ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK,
                        ple_pkg::OP_INS_AT: begin
                            if (full) begin
                                n_strobe = 1'b1;
                                n_out.status = ple_pkg::STAT_FULL;
                            end else if (i_cmd.op == ple_pkg::OP_INS_BACK) begin
                                mem_we   = 1'b1;
                                mem_wa   = r_count[IW-1:0];
                                mem_wd   = i_cmd.value;
                                n_count  = r_count + CW'(1);
                                n_strobe = 1'b1;
                            end else if (i_cmd.op == ple_pkg::OP_INS_FRONT) begin
                                n_base = '0;
                                n_left = r_count;
                                n_idx  = cnt_m1[IW-1:0];
                            end else if (ins_ok) begin
                                n_base = at;
                                n_left = r_count - CW'(at);
                                n_idx  = cnt_m1[IW-1:0];
                            end else begin
                                n_strobe = 1'b1;
                                n_out.status = ple_pkg::STAT_RANGE;
                            end
                        end
                        ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK,
                        ple_pkg::OP_DEL_AT, ple_pkg::OP_UPDATE: begin
                            if (empty) begin
                                n_strobe = 1'b1;
                                n_out.status = ple_pkg::STAT_EMPTY;
                            end else if (i_cmd.op == ple_pkg::OP_DEL_BACK) begin
                                n_count  = cnt_m1;
                                n_strobe = 1'b1;
                            end else if (i_cmd.op == ple_pkg::OP_DEL_FRONT) begin
                                n_left = cnt_m1;
                                n_idx  = IW'(1);
                            end else if (!pos_ok) begin
                                n_strobe = 1'b1;
                                n_out.status = ple_pkg::STAT_RANGE;
                            end else if (i_cmd.op == ple_pkg::OP_DEL_AT) begin
                                n_base = at;
                                n_left = cnt_m1 - CW'(at);
                                n_idx  = at_p1;
                            end else begin
                                mem_we   = 1'b1;
                                mem_wa   = at;
                                mem_wd   = i_cmd.value;
                                n_strobe = 1'b1;
                            end
                        end
                        ple_pkg::OP_SEARCH, ple_pkg::OP_DUMP: begin
                            if (empty) begin
                                n_strobe = 1'b1;
                                n_out.status = ple_pkg::STAT_EMPTY;
                            end else begin
                                n_left    = r_count;
                                n_idx     = '0;
                                n_hit_vld = 1'b0;
                            end
                        end
                        ple_pkg::OP_CLEAR: begin
                            n_strobe = 1'b1;
                            if (empty) n_out.status = ple_pkg::STAT_EMPTY;
                            else n_count = '0;
                        end
                        ple_pkg::OP_SIZE: begin
                            n_strobe = 1'b1;
                            if (empty) n_out.status = ple_pkg::STAT_EMPTY;
                        end
                        default: n_strobe = 1'b0;
                    endcase
                    n_out.last = 1'b1;
                end
            end
            ple_pkg::ST_OPEN: begin
                if (r_left != '0) begin
                    n_idx       = r_idx - IW'(1);
                    n_left      = r_left - CW'(1);
                    n_pend      = 1'b1;
                    n_pend_addr = r_idx;
                end
                if (r_pend) begin
                    mem_we = 1'b1;
                    mem_wa = r_pend_addr + IW'(1);
                    mem_wd = r_rd_data;
                end else if (r_left == '0) begin
                    mem_we     = 1'b1;
                    mem_wa     = r_base;
                    mem_wd     = r_val;
                    n_count    = r_count + CW'(1);
                    n_strobe   = 1'b1;
                    n_out.last = 1'b1;
                end
            end
            ple_pkg::ST_CLOSE: begin
                if (r_left != '0) begin
                    n_idx       = r_idx + IW'(1);
                    n_left      = r_left - CW'(1);
                    n_pend      = 1'b1;
                    n_pend_addr = r_idx;
                end
                if (r_pend) begin
                    mem_we = 1'b1;
                    mem_wa = r_pend_addr - IW'(1);
                    mem_wd = r_rd_data;
                end else if (r_left == '0) begin
                    n_count    = cnt_m1;
                    n_strobe   = 1'b1;
                    n_out.last = 1'b1;
                end
            end
            ple_pkg::ST_SEARCH: begin
                if (r_left != '0) begin
                    n_idx       = r_idx + IW'(1);
                    n_left      = r_left - CW'(1);
                    n_pend      = 1'b1;
                    n_pend_addr = r_idx;
                end
                // a hit is held back until the next one, or the end, settles last
                if (r_pend) begin
                    if (r_rd_data == r_val) begin
                        if (r_hit_vld) begin
                            n_strobe         = 1'b1;
                            n_out.item_value = r_hit_val;
                            n_out.item_pos   = r_hit_pos;
                        end
                        n_hit_vld = 1'b1;
                        n_hit_val = r_rd_data;
                        n_hit_pos = 6'(pend_pos);
                    end
                end else if (r_left == '0) begin
                    n_strobe   = 1'b1;
                    n_out.last = 1'b1;
                    if (r_hit_vld) begin
                        n_out.item_value = r_hit_val;
                        n_out.item_pos   = r_hit_pos;
                    end else begin
                        n_out.status = ple_pkg::STAT_NOTFOUND;
                    end
                end
            end
            ple_pkg::ST_DUMP: begin
                if (r_left != '0) begin
                    n_idx       = r_idx + IW'(1);
                    n_left      = r_left - CW'(1);
                    n_pend      = 1'b1;
                    n_pend_addr = r_idx;
                end
                if (r_pend) begin
                    n_strobe         = 1'b1;
                    n_out.item_value = r_rd_data;
                    n_out.item_pos   = 6'(pend_pos);
                    n_out.last       = (r_left == '0);
                end
            end
            default: n_strobe = 1'b0;
        endcase

        n_out.length = 6'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd_data <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ple_pkg::ST_IDLE;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_hit_vld <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_hit_vld <= n_hit_vld;
            r_strobe  <= n_strobe;
        end
        r_left      <= n_left;
        r_idx       <= n_idx;
        r_base      <= n_base;
        r_val       <= n_val;
        r_pend_addr <= n_pend_addr;
        r_hit_val   <= n_hit_val;
        r_hit_pos   <= n_hit_pos;
        r_out       <= n_out;
    end

    assign busy     = (r_state != ple_pkg::ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count beyond capacity");

    a_idle_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ple_pkg::ST_IDLE) |-> !r_pend)
        else $error("memory read left in flight at idle");

    a_length_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.length == 6'(r_count)))
        else $error("reported length differs from stored count");

    a_dump_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ple_pkg::ST_DUMP && r_pend && r_left == '0)
        |=> (r_state == ple_pkg::ST_IDLE && o_strobe && o_result.last))
        else $error("dump did not close with a final transfer");

endmodule
